// File: rtl/cal_pkg.sv
// Package with opcodes and stream field widths for the complex arithmetic unit.
`timescale 1ns / 1ps
package cal_pkg;

  localparam int OP_W   = 3;
  localparam int DATA_W = 16;

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV = 3'd3;
  localparam logic [OP_W-1:0] OP_EQ  = 3'd4;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 40;

  localparam int PROD_W = 2 * DATA_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int PRE_W  = SUM_W + 1;

  localparam int Q_W = DATA_W + 1;

endpackage

// File: rtl/complex_arith_alu.sv
// Top level of the pipelined complex arithmetic unit on signed fixed-point operands.
`timescale 1ns / 1ps
// Usage:
//   Slave stream s_axis_* carries one operation per transfer: opcode and operands a, b.
//   Master stream m_axis_* returns exactly one result per input transfer, in order:
//   real and imaginary result parts plus equal, divide-by-zero and overflow flags.
//   Opcodes: add, subtract, multiply, divide, equality test; unused opcodes give zeros.
//   Throughput: one transfer per cycle while the receiver accepts results.
//   Stages: input register, four products and two squares, sums, divider setup,
//   one restoring quotient bit per part per stage (17 stages, each a compare and
//   subtract on both the real and imaginary parts), then saturation into the
//   output register. The divider stages set the depth.
//   Every stage has its own valid bit and loads whenever it is empty or the stage
//   after it moves, so bubbles are squeezed out while the receiver stalls and
//   s_axis_tready stays high until every stage holds an item.
//   Reset clears all valid bits; the payload registers are not reset.
//   FRAC_BITS sets the fraction width of the fixed-point format (0 to 15).
module complex_arith_alu
  import cal_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // op[2:0], a_re[18:3], a_im[34:19], b_re[50:35], b_im[66:51], zero[71:67]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // res_re[15:0], res_im[31:16], is_equal[32], div_zero[33], overflow[34], zero[39:35]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int NQ  = Q_W;
  localparam int NW  = PROD_W + FRAC_BITS;
  localparam int W   = (NW > PROD_W + NQ) ? NW : PROD_W + NQ;
  localparam int NS  = NQ + 5;
  localparam int IST = 3;
  localparam int OST = NS - 1;
  localparam logic signed [PRE_W-1:0] RND = PRE_W'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic signed [PRE_W-1:0] BIG = PRE_W'(64'd1 << NQ);

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic                    eq;
    logic                    dz;
    logic signed [PRE_W-1:0] pre_re;
    logic signed [PRE_W-1:0] pre_im;
    logic                    neg_re;
    logic                    neg_im;
    logic                    big_re;
    logic                    big_im;
    logic [W-1:0]            rem_re;
    logic [W-1:0]            rem_im;
    logic [NQ-1:0]           q_re;
    logic [NQ-1:0]           q_im;
    logic [PROD_W-1:0]       den;
  } st_t;

  function automatic logic [DATA_W:0] clamp(input logic signed [PRE_W-1:0] v);
    logic [DATA_W:0] r;
    if (v > PRE_W'(32767)) begin
      r = {1'b1, 16'h7fff};
    end else if (v < -PRE_W'(32768)) begin
      r = {1'b1, 16'h8000};
    end else begin
      r = {1'b0, v[DATA_W-1:0]};
    end
    return r;
  endfunction

  logic [NS-1:0] v_q;
  logic [NS-1:0] rdy;

  // stage 0: operands
  logic [OP_W-1:0]          op0_q;
  logic signed [DATA_W-1:0] ar0_q, ai0_q, br0_q, bi0_q;
  // stage 1: products, add/subtract sums and equality compare
  logic [OP_W-1:0]          op1_q;
  logic                     eq1_q;
  logic signed [PROD_W-1:0] prr_q, pii_q, pri_q, pir_q, sqr_q, sqi_q;
  logic signed [DATA_W:0]   sr1_q, si1_q;
  // stage 2: sums
  logic [OP_W-1:0]          op2_q;
  logic                     eq2_q;
  logic signed [SUM_W-1:0]  ar_q, am_q, mre_q, mim_q, dre_q, dim_q;
  logic [PROD_W-1:0]        den2_q;
  // divider stages
  st_t st_q [NQ+1];
  st_t st_d [NQ+1];
  logic [OUT_TDATA_W-1:0]   out_d, out_q;

  always_comb begin
    rdy[NS-1] = !v_q[NS-1] || m_axis_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = v_q[OST];
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      op0_q <= s_axis_tdata[2:0];
      ar0_q <= s_axis_tdata[18:3];
      ai0_q <= s_axis_tdata[34:19];
      br0_q <= s_axis_tdata[50:35];
      bi0_q <= s_axis_tdata[66:51];
    end
    if (rdy[1]) begin
      op1_q <= op0_q;
      eq1_q <= (ar0_q == br0_q) && (ai0_q == bi0_q);
      prr_q <= ar0_q * br0_q;
      pii_q <= ai0_q * bi0_q;
      pri_q <= ar0_q * bi0_q;
      pir_q <= ai0_q * br0_q;
      sqr_q <= br0_q * br0_q;
      sqi_q <= bi0_q * bi0_q;
      sr1_q <= (op0_q == OP_SUB) ? (Q_W'(ar0_q) - Q_W'(br0_q)) : (Q_W'(ar0_q) + Q_W'(br0_q));
      si1_q <= (op0_q == OP_SUB) ? (Q_W'(ai0_q) - Q_W'(bi0_q)) : (Q_W'(ai0_q) + Q_W'(bi0_q));
    end
    if (rdy[2]) begin
      op2_q  <= op1_q;
      eq2_q  <= eq1_q;
      ar_q   <= SUM_W'(sr1_q);
      am_q   <= SUM_W'(si1_q);
      mre_q  <= SUM_W'(prr_q) - SUM_W'(pii_q);
      mim_q  <= SUM_W'(pri_q) + SUM_W'(pir_q);
      dre_q  <= SUM_W'(prr_q) + SUM_W'(pii_q);
      dim_q  <= SUM_W'(pir_q) - SUM_W'(pri_q);
      den2_q <= PROD_W'(sqr_q) + PROD_W'(sqi_q);
    end
    for (int k = 0; k <= NQ; k++) begin
      if (rdy[IST+k]) begin
        st_q[k] <= st_d[k];
      end
    end
    if (rdy[OST]) begin
      out_q <= out_d;
    end
  end

  // divider setup and multiply truncation
  always_comb begin
    logic [SUM_W-1:0] mag_re, mag_im;
    logic [W-1:0]     n_re, n_im;
    logic signed [PRE_W-1:0] s_re, s_im;
    mag_re = dre_q[SUM_W-1] ? SUM_W'(-dre_q) : SUM_W'(dre_q);
    mag_im = dim_q[SUM_W-1] ? SUM_W'(-dim_q) : SUM_W'(dim_q);
    n_re   = W'(mag_re) << FRAC_BITS;
    n_im   = W'(mag_im) << FRAC_BITS;
    s_re   = PRE_W'(mre_q);
    s_im   = PRE_W'(mim_q);
    st_d[0]        = '0;
    st_d[0].op     = op2_q;
    st_d[0].eq     = eq2_q;
    st_d[0].dz     = (den2_q == '0);
    st_d[0].den    = den2_q;
    st_d[0].neg_re = dre_q[SUM_W-1];
    st_d[0].neg_im = dim_q[SUM_W-1];
    st_d[0].rem_re = n_re;
    st_d[0].rem_im = n_im;
    st_d[0].big_re = (n_re >> NQ) >= W'(den2_q);
    st_d[0].big_im = (n_im >> NQ) >= W'(den2_q);
    case (op2_q)
      OP_ADD, OP_SUB: begin
        st_d[0].pre_re = PRE_W'(ar_q);
        st_d[0].pre_im = PRE_W'(am_q);
      end
      default: begin
        st_d[0].pre_re = $signed(s_re + (s_re[PRE_W-1] ? RND : '0)) >>> FRAC_BITS;
        st_d[0].pre_im = $signed(s_im + (s_im[PRE_W-1] ? RND : '0)) >>> FRAC_BITS;
      end
    endcase
  end

  for (genvar k = 1; k <= NQ; k++) begin : g_div
    always_comb begin
      logic [W-1:0] dsh;
      dsh     = W'(st_q[k-1].den) << (NQ - k);
      st_d[k] = st_q[k-1];
      if (st_q[k-1].rem_re >= dsh) begin
        st_d[k].rem_re       = st_q[k-1].rem_re - dsh;
        st_d[k].q_re[NQ-k]   = 1'b1;
      end
      if (st_q[k-1].rem_im >= dsh) begin
        st_d[k].rem_im       = st_q[k-1].rem_im - dsh;
        st_d[k].q_im[NQ-k]   = 1'b1;
      end
    end
  end

  always_comb begin
    st_t s;
    logic signed [PRE_W-1:0] vre, vim;
    logic [DATA_W:0] cre, cim;
    logic eq, dz;
    s   = st_q[NQ];
    vre = '0;
    vim = '0;
    eq  = 1'b0;
    dz  = 1'b0;
    case (s.op)
      OP_ADD, OP_SUB, OP_MUL: begin
        vre = s.pre_re;
        vim = s.pre_im;
      end
      OP_DIV: begin
        if (s.dz) begin
          dz = 1'b1;
        end else begin
          vre = s.big_re ? BIG : PRE_W'({1'b0, s.q_re});
          vim = s.big_im ? BIG : PRE_W'({1'b0, s.q_im});
          if (s.neg_re) begin
            vre = -vre;
          end
          if (s.neg_im) begin
            vim = -vim;
          end
        end
      end
      OP_EQ: begin
        eq = s.eq;
      end
      default: begin
        eq = 1'b0;
      end
    endcase
    cre   = clamp(vre);
    cim   = clamp(vim);
    out_d = {5'b0, cre[DATA_W] | cim[DATA_W], dz, eq,
             cim[DATA_W-1:0], cre[DATA_W-1:0]};
  end

endmodule
